[rtl/core/tggns_pkg.sv]
package tggns_pkg;

  localparam int unsigned MaxPointsDefault = 1024;
  localparam int unsigned CoordWidthDefault = 24;
  localparam int unsigned SpreadWidth = 16;
  localparam int unsigned SumWidth = 27;
  localparam int unsigned QueryIndexWidth = 10;
  localparam int unsigned CfgIndexWidth = 1;
  localparam logic [SpreadWidth-1:0] SpreadReset = 16'd16;
  localparam logic [SumWidth-1:0] SumMax = {SumWidth{1'b1}};

  typedef enum logic [1:0] {
    ActLoad  = 2'd0,
    ActQuery = 2'd1,
    ActClear = 2'd2,
    ActNone  = 2'd3
  } action_e;

  typedef enum logic [CfgIndexWidth-1:0] {
    CfgSpreadFirst  = 1'b0,
    CfgSpreadSecond = 1'b1
  } cfg_index_e;

  typedef enum logic [2:0] {
    StIdle,
    StFetchQ,
    StLatchQ,
    StScan,
    StDrain,
    StOut
  } ctrl_state_e;

  typedef enum logic [3:0] {
    WtIdle,
    WtDiv,
    WtP2,
    WtP3,
    WtP4,
    WtPoly,
    WtSum,
    WtSq,
    WtDone
  } wt_state_e;

  typedef struct packed {
    logic                 start;
    logic [63:0]          sq_dist;
  } wt_req_t;

  typedef struct packed {
    logic                 done;
    logic [16:0]          weight;
  } wt_rsp_t;

endpackage

[rtl/core/tggns_if.sv]
interface tggns_in_if #(
  parameter int unsigned CoordWidth = 24
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            action;
  logic signed [CoordWidth-1:0] x_coord;
  logic signed [CoordWidth-1:0] y_coord;
  logic                  in_group_one;
  logic [9:0]            query_index;
  modport source(output valid, action, x_coord, y_coord, in_group_one, query_index,
                 input ready);
  modport sink(input valid, action, x_coord, y_coord, in_group_one, query_index,
               output ready);
endinterface

interface tggns_out_if;
  logic        valid;
  logic        ready;
  logic [26:0] sum_group_one;
  logic [26:0] sum_group_two;
  logic        status;
  modport source(output valid, sum_group_one, sum_group_two, status, input ready);
  modport sink(input valid, sum_group_one, sum_group_two, status, output ready);
endinterface

[rtl/core/tggns_weight.sv]
module tggns_weight (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [15:0]                 s1_i,
  input  logic [15:0]                 s2_i,
  input  tggns_pkg::wt_req_t          req_i,
  output tggns_pkg::wt_rsp_t          rsp_o
);
  import tggns_pkg::*;

  wt_state_e   state_q, state_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [32:0] rem_q, rem_d;
  logic [63:0] quo_q, quo_d;
  logic [33:0] den;
  logic [33:0] shifted;
  logic [31:0] s_q, s_d, p2_q, p2_d, p3_q, p3_d, p4_q, p4_d, e_q, e_d;
  logic [63:0] prod;
  logic [31:0] rnd;
  logic [31:0] mul_a, mul_b;
  logic [63:0] p3_recip, p4_recip;
  logic [31:0] p3_div, p4_div;
  logic [33:0] poly;

  assign den = {1'b0, 32'(s1_i) * 32'(s2_i), 1'b0};
  assign shifted = {rem_q, quo_q[63]};

  always_comb begin
    mul_a = s_q;
    mul_b = s_q;
    case (state_q)
      WtP3: begin mul_a = s_q;  mul_b = s_q; end
      WtP4: begin mul_a = p2_q; mul_b = s_q; end
      WtPoly: begin mul_a = p3_q; mul_b = s_q; end
      WtSq: begin mul_a = e_q;  mul_b = e_q; end
      default: begin mul_a = s_q; mul_b = s_q; end
    endcase
  end

  assign prod = mul_a * mul_b;
  assign rnd = 32'((prod + 64'h4000_0000) >> 31);

  // divide by 3 through the reciprocal, then drop 1 or 3 more bits
  assign p3_recip = p3_q * 32'hAAAA_AAAB;
  assign p4_recip = p4_q * 32'hAAAA_AAAB;
  assign p3_div = 32'(p3_recip >> 34);
  assign p4_div = 32'(p4_recip >> 36);

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    rem_d = rem_q;
    quo_d = quo_q;
    s_d = s_q;
    p2_d = p2_q;
    p3_d = p3_q;
    p4_d = p4_q;
    e_d = e_q;
    poly = '0;
    case (state_q)
      WtIdle: begin
        if (req_i.start) begin
          rem_d = '0;
          quo_d = 64'({req_i.sq_dist, 16'd0} + 80'(den[33:1]));
          cnt_d = 7'd64;
          state_d = WtDiv;
        end
      end
      WtDiv: begin
        rem_d = shifted[32:0];
        quo_d = {quo_q[62:0], 1'b0};
        if (shifted >= den) begin
          rem_d = 33'(shifted - den);
          quo_d = {quo_q[62:0], 1'b1};
        end
        cnt_d = cnt_q - 7'd1;
        if (cnt_q == 7'd1) state_d = WtP2;
      end
      WtP2: begin
        if (quo_q >= 64'(12 << 16)) begin
          e_d = '0;
          state_d = WtDone;
        end else begin
          s_d = 32'(quo_q << 7);
          state_d = WtP3;
        end
      end
      WtP3: begin
        p2_d = rnd;
        state_d = WtP4;
      end
      WtP4: begin
        p3_d = rnd;
        state_d = WtPoly;
      end
      WtPoly: begin
        p4_d = rnd;
        state_d = WtSum;
      end
      WtSum: begin
        poly = 34'h0_8000_0000 - 34'(s_q) + 34'(p2_q >> 1) - 34'(p3_div)
               + 34'(p4_div);
        e_d = poly[31:0];
        cnt_d = 7'd8;
        state_d = WtSq;
      end
      WtSq: begin
        e_d = rnd;
        cnt_d = cnt_q - 7'd1;
        if (cnt_q == 7'd1) state_d = WtDone;
      end
      WtDone: state_d = WtIdle;
      default: state_d = WtIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= WtIdle;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    s_q <= s_d;
    p2_q <= p2_d;
    p3_q <= p3_d;
    p4_q <= p4_d;
    e_q <= e_d;
  end

  assign rsp_o.done = (state_q == WtDone);
  assign rsp_o.weight = 17'((33'(e_q) + 33'h4000) >> 15);
endmodule

[rtl/core/two_group_gaussian_neighbour_sum_top.sv]
// Gaussian neighbour sum over a point store, two groups.
// Input channel in_if: word with action, x/y coordinates, group flag and
// query index. Output channel out_if: two Q16 sums and a status bit.
// Load: the point goes to the next free store entry (ignored when the
// store is full). Clear: the fill count drops to zero.
// Query: the store is scanned entry by entry through its one read port;
// each neighbour within the radius runs the weight unit (a 64-step
// restoring divider plus 11 multiply steps) before the scan moves on.
// The result word is offered once the scan has passed every entry; a
// bad index skips the scan and offers it with status set. One word is
// in flight at a time.
// Configuration writes on cfg_we_i/cfg_idx_i/cfg_wdata_i set the spreads;
// write only while idle.
// Reset clears the fill count and the control; store contents stay
// undefined and are never read unless written.
// When the receiver stalls, the result word is held and no new word is
// taken until it is delivered.
module two_group_gaussian_neighbour_sum_top #(
  parameter int unsigned MaxPoints  = tggns_pkg::MaxPointsDefault,
  parameter int unsigned CoordWidth = tggns_pkg::CoordWidthDefault
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [tggns_pkg::CfgIndexWidth-1:0]     cfg_idx_i,
  input  logic [tggns_pkg::SpreadWidth-1:0]       cfg_wdata_i,
  tggns_in_if.sink                                in_if,
  tggns_out_if.source                             out_if
);
  import tggns_pkg::*;

  localparam int unsigned AddrW = $clog2(MaxPoints);
  localparam int unsigned CntW = $clog2(MaxPoints + 1);
  localparam int unsigned EntW = 2 * CoordWidth + 1;
  localparam int unsigned CmpW = CoordWidth + 17;

  logic [EntW-1:0] mem [MaxPoints];
  logic [EntW-1:0] rd_q;
  logic [AddrW-1:0] rd_addr;
  logic             we;

  logic [15:0] sf_q, ss_q, s1, s2, m;
  ctrl_state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d, idx_q, idx_d;
  logic [CoordWidth-1:0] qx_q, qx_d, qy_q, qy_d;
  logic [SumWidth:0] sum1_q, sum1_d, sum2_q, sum2_d;
  logic st_q, st_d;
  logic grp_q, grp_d, wait_q, wait_d;
  logic [CoordWidth:0] ax, ay;
  logic [31:0] sq_x, sq_y, rad_sq;
  logic [32:0] sq_sum;
  logic near_hit;
  logic [63:0] dist_q, dist_d;
  logic near_q, near_d;
  wt_req_t req;
  wt_rsp_t rsp;

  assign s1 = (sf_q == '0) ? 16'd1 : sf_q;
  assign s2 = (ss_q == '0) ? 16'd1 : ss_q;
  assign m = (s1 > s2) ? s1 : s2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sf_q <= SpreadReset;
      ss_q <= SpreadReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgSpreadFirst:  sf_q <= cfg_wdata_i;
        CfgSpreadSecond: ss_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign we = in_if.valid && in_if.ready && (in_if.action == ActLoad)
              && (cnt_q < CntW'(MaxPoints));

  always_ff @(posedge clk_i) begin
    if (we) mem[cnt_q[AddrW-1:0]] <= {in_if.x_coord, in_if.y_coord, in_if.in_group_one};
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    ax = (signed'(rd_q[EntW-1 -: CoordWidth]) >= signed'(qx_q))
       ? (CoordWidth+1)'(signed'(rd_q[EntW-1 -: CoordWidth]) - signed'(qx_q))
       : (CoordWidth+1)'(signed'(qx_q) - signed'(rd_q[EntW-1 -: CoordWidth]));
    ay = (signed'(rd_q[CoordWidth:1]) >= signed'(qy_q))
       ? (CoordWidth+1)'(signed'(rd_q[CoordWidth:1]) - signed'(qy_q))
       : (CoordWidth+1)'(signed'(qy_q) - signed'(rd_q[CoordWidth:1]));
  end

  // squares only matter once both offsets are within the 16-bit radius
  assign sq_x = 32'(16'(ax)) * 32'(16'(ax));
  assign sq_y = 32'(16'(ay)) * 32'(16'(ay));
  assign sq_sum = 33'(sq_x) + 33'(sq_y);
  assign rad_sq = 32'(m) * 32'(m);
  assign near_hit = (CmpW'(ax) <= CmpW'(m)) && (CmpW'(ay) <= CmpW'(m)) &&
                    (sq_sum <= 33'(rad_sq));

  assign in_if.ready = (state_q == StIdle);
  assign out_if.valid = (state_q == StOut);
  assign out_if.sum_group_one = (sum1_q > (SumWidth+1)'(SumMax)) ? SumMax : sum1_q[SumWidth-1:0];
  assign out_if.sum_group_two = (sum2_q > (SumWidth+1)'(SumMax)) ? SumMax : sum2_q[SumWidth-1:0];
  assign out_if.status = st_q;

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    idx_d = idx_q;
    qx_d = qx_q;
    qy_d = qy_q;
    sum1_d = sum1_q;
    sum2_d = sum2_q;
    st_d = st_q;
    grp_d = grp_q;
    wait_d = wait_q;
    dist_d = dist_q;
    near_d = 1'b0;
    rd_addr = idx_q[AddrW-1:0];
    req.start = 1'b0;
    req.sq_dist = dist_q;
    case (state_q)
      StIdle: begin
        rd_addr = AddrW'(in_if.query_index);
        if (in_if.valid) begin
          case (in_if.action)
            ActLoad: if (we) cnt_d = cnt_q + CntW'(1);
            ActClear: cnt_d = '0;
            ActQuery: begin
              sum1_d = '0;
              sum2_d = '0;
              idx_d = '0;
              st_d = (CntW'(in_if.query_index) >= cnt_q) ||
                     (32'(in_if.query_index) >= MaxPoints);
              state_d = StFetchQ;
            end
            default: ;
          endcase
        end
      end
      StFetchQ: begin
        if (st_q) state_d = StOut;
        else begin
          qx_d = rd_q[EntW-1 -: CoordWidth];
          qy_d = rd_q[CoordWidth:1];
          state_d = StLatchQ;
        end
      end
      StLatchQ: begin
        rd_addr = '0;
        state_d = StScan;
      end
      StScan: begin
        // rd_q holds entry idx_q
        if (wait_q) begin
          if (rsp.done) begin
            if (grp_q) sum1_d = sum1_q + (SumWidth+1)'(rsp.weight);
            else sum2_d = sum2_q + (SumWidth+1)'(rsp.weight);
            wait_d = 1'b0;
            state_d = StDrain;
          end
        end else begin
          dist_d = 64'(sq_sum);
          grp_d = rd_q[0];
          if (near_hit) begin
            wait_d = 1'b1;
            near_d = 1'b1;
          end else begin
            state_d = StDrain;
          end
        end
        req.start = near_q;
      end
      StDrain: begin
        idx_d = idx_q + CntW'(1);
        rd_addr = idx_d[AddrW-1:0];
        if (idx_d >= cnt_q) state_d = StOut;
        else state_d = StLatchQ;
        if (idx_d < cnt_q) state_d = StScan;
      end
      StOut: if (out_if.ready) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q <= '0;
      wait_q <= 1'b0;
      near_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      wait_q <= wait_d;
      near_q <= near_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    qx_q <= qx_d;
    qy_q <= qy_d;
    sum1_q <= sum1_d;
    sum2_q <= sum2_d;
    st_q <= st_d;
    grp_q <= grp_d;
    dist_q <= dist_d;
  end

  tggns_weight u_weight (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .s1_i   (s1),
    .s2_i   (s2),
    .req_i  (req),
    .rsp_o  (rsp)
  );
endmodule

[rtl/core/tggns_checker.sv]
module tggns_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_action,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_status,
  input logic [26:0] out_sum_one,
  input logic [26:0] out_sum_two
);
  import tggns_pkg::*;

  a_no_take_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready) else $error("input taken with result pending");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_status) |-> (out_sum_one == '0 && out_sum_two == '0))
    else $error("bad query with nonzero sums");

  a_load_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready && (in_action == ActLoad || in_action == ActClear))
    |=> !out_valid) else $error("result after load or clear");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_sum_one)))
    else $error("result dropped while stalled");
endmodule

bind two_group_gaussian_neighbour_sum_top tggns_checker u_tggns_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .in_action   (in_if.action),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .out_status  (out_if.status),
  .out_sum_one (out_if.sum_group_one),
  .out_sum_two (out_if.sum_group_two)
);
